FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication check
`define FFHA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication check
`define FFHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/ffha_pkg.sv
`default_nettype none

package ffha_pkg;

    localparam int HEAP_BYTES_DEF        = 8192;
    localparam int HEADER_BYTES_DEF      = 32;
    localparam int MIN_PAYLOAD_BYTES_DEF = 4;
    localparam int MAX_BLOCKS_DEF        = 256;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_COUNT = 2'd3
    } cmd_e;

    typedef enum logic [2:0] {
        OP_HOLD   = 3'd0,
        OP_ROTATE = 3'd1,
        OP_WRITE  = 3'd2,
        OP_RESIZE = 3'd3,
        OP_INSERT = 3'd4,
        OP_DELETE = 3'd5
    } op_kind_e;

    typedef struct packed {
        logic [15:0] size;
        logic        free;
        logic [7:0]  owner;
    } entry_t;

    typedef struct packed {
        cmd_e        command;
        logic [15:0] size;
        logic [15:0] address;
        logic [7:0]  task_id;
    } in_t;

    typedef struct packed {
        logic        status;
        logic [15:0] block_address;
        logic [8:0]  small_count;
    } out_t;

endpackage

`default_nettype wire

FILE: design/ffha_cell.sv
`default_nettype none

module ffha_cell #(
    parameter int             IW  = 8,
    parameter logic [IW-1:0]  POS = '0
) (
    input  wire logic              clk,
    input  wire ffha_pkg::op_kind_e op_kind,
    input  wire logic [IW-1:0]     op_idx,
    input  wire ffha_pkg::entry_t  op_data,
    input  wire ffha_pkg::entry_t  left_entry,
    input  wire ffha_pkg::entry_t  right_entry,
    output ffha_pkg::entry_t       entry
);

    ffha_pkg::entry_t entry_reg;
    ffha_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (op_kind)
            ffha_pkg::OP_HOLD:   entry_next = entry_reg;
            ffha_pkg::OP_ROTATE: entry_next = right_entry;
            ffha_pkg::OP_WRITE:
            begin
                if (op_idx == POS) entry_next = op_data;
            end
            ffha_pkg::OP_RESIZE:
            begin
                if (op_idx == POS) entry_next.size = op_data.size;
            end
            ffha_pkg::OP_INSERT:
            begin
                if (POS > op_idx)       entry_next = left_entry;
                else if (POS == op_idx) entry_next = op_data;
            end
            ffha_pkg::OP_DELETE:
            begin
                if (POS >= op_idx) entry_next = right_entry;
            end
            default: entry_next = entry_reg;
        endcase
    end

    // descriptor payload, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

FILE: design/first_fit_heap_allocator_core.sv
// sequence: init goes through edit to done and early rejects go straight to done; alloc, free and count
// rotate the whole chain in scan, then pass fin and up to 3 queued edits before done
// throughput: one transaction at a time, set by the full rotation of the descriptor chain
// reset: rst_n async active low clears control state, kernel_ready and heap_ready; the
// descriptor cells are not cleared, only entries below the block count are ever used
// the receiver cannot stall: done is high for exactly one cycle with the result
`default_nettype none

module first_fit_heap_allocator_core #(
    parameter int HEAP_BYTES        = ffha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES      = ffha_pkg::HEADER_BYTES_DEF,
    parameter int MIN_PAYLOAD_BYTES = ffha_pkg::MIN_PAYLOAD_BYTES_DEF,
    parameter int MAX_BLOCKS        = ffha_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire ffha_pkg::in_t cmd,
    output logic               done,
    output ffha_pkg::out_t     result,
    input  wire logic          cfg_we,
    input  wire logic          cfg_wdata
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    localparam logic [16:0]   HDR17     = 17'(HEADER_BYTES);
    localparam logic [17:0]   HDR18     = 18'(HEADER_BYTES);
    localparam logic [17:0]   MIN18     = 18'(MIN_PAYLOAD_BYTES);
    localparam logic [15:0]   HDR16     = 16'(HEADER_BYTES);
    localparam logic [15:0]   INIT_SIZE = 16'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [IW-1:0] LAST_POS  = IW'(MAX_BLOCKS - 1);
    localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_BLOCKS);

    // one-hot controller states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_FIN  = 5'b00100,
        S_EDIT = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // chain of descriptor cells; cell 0 is the head seen by the scan logic
    ffha_pkg::entry_t cell_q [MAX_BLOCKS];
    ffha_pkg::entry_t tail_entry;
    ffha_pkg::op_kind_e chain_kind;
    logic [IW-1:0]      chain_idx;
    ffha_pkg::entry_t   chain_data;

    // queued table edits applied after the scan
    ffha_pkg::op_kind_e op_kind_reg [3];
    ffha_pkg::op_kind_e op_kind_next [3];
    logic [IW-1:0]      op_idx_reg [3];
    logic [IW-1:0]      op_idx_next [3];
    ffha_pkg::entry_t   op_data_reg [3];
    ffha_pkg::entry_t   op_data_next [3];
    logic [1:0]         op_n_reg, op_n_next;
    logic [1:0]         op_ptr_reg, op_ptr_next;

    ffha_pkg::in_t  cmd_reg, cmd_next;
    ffha_pkg::out_t result_reg, result_next;
    logic [16:0]    need_reg, need_next;
    logic [IW-1:0]  r_reg, r_next;
    logic [16:0]    pos_reg, pos_next;
    logic           found_reg, found_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic [15:0]    baddr_reg, baddr_next;
    logic           split_reg, split_next;
    logic [15:0]    rest_reg, rest_next;
    logic           prev_free_reg, prev_free_next;
    logic [15:0]    prev_size_reg, prev_size_next;
    logic [15:0]    cur_size_reg, cur_size_next;
    logic           next_free_reg, next_free_next;
    logic [15:0]    next_size_reg, next_size_next;
    logic           look_next_reg, look_next_next;
    logic           last_free_reg, last_free_next;
    logic [15:0]    last_size_reg, last_size_next;
    logic [8:0]     cnt_reg, cnt_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           heap_ready_reg, heap_ready_next;
    logic           kernel_ready_reg;

    ffha_pkg::entry_t head;
    logic             head_valid;
    logic             hit_alloc;
    logic             hit_free;
    logic             split_ok;
    logic [17:0]      split_need;

    genvar g;
    generate
        for (g = 0; g < MAX_BLOCKS; g++)
        begin : g_cell
            ffha_pkg::entry_t left_e;
            ffha_pkg::entry_t right_e;
            if (g == 0)
            begin : g_first
                assign left_e = cell_q[MAX_BLOCKS-1];
            end
            else
            begin : g_mid_l
                assign left_e = cell_q[g-1];
            end
            if (g == MAX_BLOCKS - 1)
            begin : g_last
                assign right_e = tail_entry;
            end
            else
            begin : g_mid_r
                assign right_e = cell_q[g+1];
            end
            ffha_cell #(
                .IW  (IW),
                .POS (IW'(g))
            ) u_cell (
                .clk         (clk),
                .op_kind     (chain_kind),
                .op_idx      (chain_idx),
                .op_data     (chain_data),
                .left_entry  (left_e),
                .right_entry (right_e),
                .entry       (cell_q[g])
            );
        end
    endgenerate

    // head of the chain is logical entry r during a scan
    assign head       = cell_q[0];
    assign head_valid = CW'(r_reg) < count_reg;
    assign split_need = 18'(need_reg) + HDR18 + MIN18;
    assign split_ok   = (18'(head.size) >= split_need) && (count_reg < MAX_CNT);

    assign hit_alloc = (cmd_reg.command == ffha_pkg::CMD_ALLOC) && !found_reg && head_valid
                     && head.free && (17'(head.size) >= need_reg);
    assign hit_free  = (cmd_reg.command == ffha_pkg::CMD_FREE) && !found_reg && head_valid
                     && !head.free && ((pos_reg + HDR17) == 17'(cmd_reg.address))
                     && (head.owner == cmd_reg.task_id);

    // the head re-enters at the tail, updated when it is the block taken or released
    always_comb
    begin
        tail_entry = head;
        if (hit_alloc)
        begin
            tail_entry.free  = 1'b0;
            tail_entry.owner = cmd_reg.task_id;
            if (split_ok) tail_entry.size = need_reg[15:0];
        end
        if (hit_free) tail_entry.free = 1'b1;
    end

    // chain command: rotate while scanning, replay queued edits afterwards
    always_comb
    begin
        chain_kind = ffha_pkg::OP_HOLD;
        chain_idx  = '0;
        chain_data = '0;
        if (state_reg == S_SCAN)
        begin
            chain_kind = ffha_pkg::OP_ROTATE;
        end
        else if (state_reg == S_EDIT)
        begin
            chain_kind = op_kind_reg[op_ptr_reg];
            chain_idx  = op_idx_reg[op_ptr_reg];
            chain_data = op_data_reg[op_ptr_reg];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        result_next     = result_reg;
        need_next       = need_reg;
        r_next          = r_reg;
        pos_next        = pos_reg;
        found_next      = found_reg;
        idx_next        = idx_reg;
        baddr_next      = baddr_reg;
        split_next      = split_reg;
        rest_next       = rest_reg;
        prev_free_next  = prev_free_reg;
        prev_size_next  = prev_size_reg;
        cur_size_next   = cur_size_reg;
        next_free_next  = next_free_reg;
        next_size_next  = next_size_reg;
        look_next_next  = look_next_reg;
        last_free_next  = last_free_reg;
        last_size_next  = last_size_reg;
        cnt_next        = cnt_reg;
        count_next      = count_reg;
        heap_ready_next = heap_ready_reg;
        op_n_next       = op_n_reg;
        op_ptr_next     = op_ptr_reg;
        for (int k = 0; k < 3; k++)
        begin
            op_kind_next[k] = op_kind_reg[k];
            op_idx_next[k]  = op_idx_reg[k];
            op_data_next[k] = op_data_reg[k];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next       = cmd;
                    need_next      = (17'(cmd.size) + 17'd3) & ~17'd3;
                    r_next         = '0;
                    pos_next       = '0;
                    found_next     = 1'b0;
                    cnt_next       = '0;
                    look_next_next = 1'b0;
                    prev_free_next = 1'b0;
                    next_free_next = 1'b0;
                    split_next     = 1'b0;
                    op_ptr_next    = '0;
                    op_n_next      = '0;
                    result_next    = '0;
                    unique case (cmd.command)
                        ffha_pkg::CMD_INIT:
                        begin
                            if (!kernel_ready_reg || heap_ready_reg)
                            begin
                                result_next.status = 1'b1;
                                state_next         = S_DONE;
                            end
                            else
                            begin
                                // one free block spanning the heap
                                op_kind_next[0] = ffha_pkg::OP_WRITE;
                                op_idx_next[0]  = '0;
                                op_data_next[0] = '{size: INIT_SIZE, free: 1'b1, owner: 8'd0};
                                op_n_next       = 2'd1;
                                count_next      = CW'(1);
                                heap_ready_next = 1'b1;
                                state_next      = S_EDIT;
                            end
                        end
                        ffha_pkg::CMD_ALLOC:
                        begin
                            if (!heap_ready_reg || cmd.size == 16'd0
                                || 17'(cmd.size) > 17'(INIT_SIZE))
                            begin
                                result_next.status = 1'b1;
                                state_next         = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ffha_pkg::CMD_FREE:
                        begin
                            if (cmd.address == 16'd0)
                            begin
                                result_next.status = 1'b1;
                                state_next         = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ffha_pkg::CMD_COUNT: state_next = S_SCAN;
                        default: state_next = S_SCAN;
                    endcase
                end
            end

            S_SCAN:
            begin
                r_next         = r_reg + IW'(1);
                last_free_next = head.free;
                last_size_next = head.size;
                if (head_valid) pos_next = pos_reg + HDR17 + 17'(head.size);
                if (cmd_reg.command == ffha_pkg::CMD_COUNT && head_valid && head.free
                    && (17'(head.size) + HDR17) < 17'(cmd_reg.size) && cnt_reg != 9'd511)
                begin
                    cnt_next = cnt_reg + 9'd1;
                end
                // neighbor right after a released block
                if (look_next_reg)
                begin
                    look_next_next = 1'b0;
                    next_free_next = head_valid && head.free;
                    next_size_next = head.size;
                end
                if (hit_alloc || hit_free)
                begin
                    found_next     = 1'b1;
                    idx_next       = r_reg;
                    baddr_next     = pos_reg[15:0] + HDR16;
                    split_next     = split_ok;
                    rest_next      = 16'(18'(head.size) - 18'(need_reg) - HDR18);
                    cur_size_next  = head.size;
                    prev_free_next = (r_reg != '0) && last_free_reg;
                    prev_size_next = last_size_reg;
                    look_next_next = hit_free;
                end
                if (r_reg == LAST_POS)
                begin
                    r_next     = '0;
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                result_next = '0;
                unique case (cmd_reg.command)
                    ffha_pkg::CMD_ALLOC:
                    begin
                        result_next.status = !found_reg;
                        if (found_reg)
                        begin
                            result_next.block_address = baddr_reg;
                            if (split_reg)
                            begin
                                op_kind_next[0] = ffha_pkg::OP_INSERT;
                                op_idx_next[0]  = idx_reg + IW'(1);
                                op_data_next[0] = '{size: rest_reg, free: 1'b1, owner: 8'd0};
                                op_n_next       = 2'd1;
                                count_next      = count_reg + CW'(1);
                            end
                        end
                    end
                    ffha_pkg::CMD_FREE:
                    begin
                        result_next.status = !found_reg;
                        if (found_reg)
                        begin
                            priority if (prev_free_reg && next_free_reg)
                            begin
                                op_kind_next[0]      = ffha_pkg::OP_RESIZE;
                                op_idx_next[0]       = idx_reg - IW'(1);
                                op_data_next[0]      = '0;
                                op_data_next[0].size = prev_size_reg + cur_size_reg
                                                     + next_size_reg + HDR16 + HDR16;
                                op_kind_next[1]      = ffha_pkg::OP_DELETE;
                                op_idx_next[1]       = idx_reg;
                                op_kind_next[2]      = ffha_pkg::OP_DELETE;
                                op_idx_next[2]       = idx_reg;
                                op_n_next            = 2'd3;
                                count_next           = count_reg - CW'(2);
                            end
                            else if (prev_free_reg)
                            begin
                                op_kind_next[0]      = ffha_pkg::OP_RESIZE;
                                op_idx_next[0]       = idx_reg - IW'(1);
                                op_data_next[0]      = '0;
                                op_data_next[0].size = prev_size_reg + cur_size_reg + HDR16;
                                op_kind_next[1]      = ffha_pkg::OP_DELETE;
                                op_idx_next[1]       = idx_reg;
                                op_n_next            = 2'd2;
                                count_next           = count_reg - CW'(1);
                            end
                            else if (next_free_reg)
                            begin
                                op_kind_next[0]      = ffha_pkg::OP_RESIZE;
                                op_idx_next[0]       = idx_reg;
                                op_data_next[0]      = '0;
                                op_data_next[0].size = cur_size_reg + next_size_reg + HDR16;
                                op_kind_next[1]      = ffha_pkg::OP_DELETE;
                                op_idx_next[1]       = idx_reg + IW'(1);
                                op_n_next            = 2'd2;
                                count_next           = count_reg - CW'(1);
                            end
                            else
                            begin
                                op_n_next = 2'd0;
                            end
                        end
                    end
                    ffha_pkg::CMD_COUNT: result_next.small_count = cnt_reg;
                    default: result_next = '0;
                endcase
                state_next = (op_n_next != 2'd0) ? S_EDIT : S_DONE;
            end

            S_EDIT:
            begin
                op_ptr_next = op_ptr_reg + 2'd1;
                if (op_ptr_next == op_n_reg) state_next = S_DONE;
            end

            S_DONE: state_next = S_IDLE;

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            kernel_ready_reg <= 1'b0;
            heap_ready_reg   <= 1'b0;
            count_reg        <= '0;
            r_reg            <= '0;
            found_reg        <= 1'b0;
            look_next_reg    <= 1'b0;
            op_n_reg         <= '0;
            op_ptr_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            heap_ready_reg <= heap_ready_next;
            count_reg      <= count_next;
            r_reg          <= r_next;
            found_reg      <= found_next;
            look_next_reg  <= look_next_next;
            op_n_reg       <= op_n_next;
            op_ptr_reg     <= op_ptr_next;
            if (cfg_we) kernel_ready_reg <= cfg_wdata;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        result_reg    <= result_next;
        need_reg      <= need_next;
        pos_reg       <= pos_next;
        idx_reg       <= idx_next;
        baddr_reg     <= baddr_next;
        split_reg     <= split_next;
        rest_reg      <= rest_next;
        prev_free_reg <= prev_free_next;
        prev_size_reg <= prev_size_next;
        cur_size_reg  <= cur_size_next;
        next_free_reg <= next_free_next;
        next_size_reg <= next_size_next;
        last_free_reg <= last_free_next;
        last_size_reg <= last_size_next;
        cnt_reg       <= cnt_next;
        for (int k = 0; k < 3; k++)
        begin
            op_kind_reg[k] <= op_kind_next[k];
            op_idx_reg[k]  <= op_idx_next[k];
            op_data_reg[k] <= op_data_next[k];
        end
    end

    // busy covers the whole transaction including the done cycle
    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_DONE);
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: design/ffha_checker.sv
`default_nettype none
`include "assert_macros.svh"

module ffha_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire logic           done,
    input wire ffha_pkg::out_t result
);

    `FFHA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `FFHA_ASSERT_NOW(a_done_in_busy, clk, rst_n, done, busy)
    `FFHA_ASSERT_NEXT(a_done_ends, clk, rst_n, done, !busy && !done)
    `FFHA_ASSERT_NOW(a_fail_no_addr, clk, rst_n, done && result.status, result.block_address == 16'd0)

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
